// ===== hw/rtl/itoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  // Field widths
  localparam int ValueWidth = 32;
  localparam int ActWidth   = 2;
  localparam int CharWidth  = 7;

  // Digit storage: ten BCD digits cover any 32-bit unsigned value
  localparam int NumDigits   = 10;
  localparam int HexDigits   = ValueWidth / 4;
  localparam int BcdWidth    = 4 * NumDigits;
  localparam int DigitCntW   = $clog2(NumDigits + 1);
  localparam int ShiftCntW   = $clog2(ValueWidth);

  // Action codes
  localparam logic [ActWidth-1:0] ActSigned   = 2'd0;
  localparam logic [ActWidth-1:0] ActUnsigned = 2'd1;
  localparam logic [ActWidth-1:0] ActHex      = 2'd2;
  localparam logic [ActWidth-1:0] ActNone     = 2'd3;

  // ASCII codes
  localparam logic [CharWidth-1:0] CharZero  = 7'h30;
  localparam logic [CharWidth-1:0] CharLowA  = 7'h61;
  localparam logic [CharWidth-1:0] CharMinus = 7'h2D;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic [ActWidth-1:0]   action;
  } itoa_in_t;

  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 last_char;
  } itoa_out_t;

  // One digit (0..15) to its lowercase ASCII character
  function automatic logic [CharWidth-1:0] nib_ascii(logic [3:0] nib);
    logic [CharWidth-1:0] code;
    if (nib >= 4'd10) begin
      code = CharLowA + {3'b000, nib} - 7'd10;
    end else begin
      code = CharZero + {3'b000, nib};
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/integer_to_ascii_formatter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Integer to ASCII formatter. Pulse start_i while busy_o is low to hand over one
// word and an action (signed decimal, unsigned decimal, lowercase hex; code 3 is
// dropped with no output). Characters come out most significant first, one per
// res_valid_o cycle, with last_char set on the final one; the receiver cannot
// stall, so every strobed beat must be taken. Leading zeros are dropped and zero
// prints as a single '0'. Decimal conversion runs a bit-serial shift-and-add-3
// converter over all 32 input bits, and a minus sign is printed from its own
// state before the digits; a hex item skips the converter, with one digit
// shifted per cycle through the digit register. The last character is strobed
// in the same cycle that busy_o falls, and a new item may start then.
module integer_to_ascii_formatter_top
  import itoa_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire itoa_in_t  in_i,
  output      logic      busy_o,
  output      logic      res_valid_o,
  output      itoa_out_t res_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;
  localparam logic [2:0] StSign = 3'd2;
  localparam logic [2:0] StSkip = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0]            state_q, state_d;
  logic                  neg_q, neg_d;
  logic [DigitCntW-1:0]  cnt_q, cnt_d;
  logic [BcdWidth-1:0]   dig_q, dig_d;
  logic                  vld_q, vld_d;
  itoa_out_t             out_q, out_d;

  logic                  accept;
  logic                  neg_in;
  logic [ValueWidth-1:0] mag;
  logic                  conv_start;
  logic                  conv_done;
  logic [BcdWidth-1:0]   conv_bcd;
  logic [3:0]            top_nib;

  assign accept = start_i && (state_q == StIdle);

  // Magnitude; the most negative value maps to itself as unsigned
  assign neg_in     = (in_i.action == ActSigned) && in_i.value[ValueWidth-1];
  assign mag        = neg_in ? (~in_i.value + 1'b1) : in_i.value;
  assign conv_start = accept && ((in_i.action == ActSigned) || (in_i.action == ActUnsigned));

  itoa_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  assign top_nib = dig_q[BcdWidth-1 -: 4];

  // Control: convert, optional sign, skip leading zeros, emit digits
  always_comb begin
    state_d         = state_q;
    neg_d           = neg_q;
    cnt_d           = cnt_q;
    dig_d           = dig_q;
    vld_d           = 1'b0;
    out_d           = out_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          neg_d = neg_in;
          unique case (in_i.action) inside
            ActSigned, ActUnsigned: begin
              state_d = StConv;
            end
            ActHex: begin
              dig_d   = {in_i.value, {(BcdWidth - ValueWidth){1'b0}}};
              cnt_d   = DigitCntW'(HexDigits);
              state_d = StSkip;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StConv: begin
        if (conv_done) begin
          dig_d   = conv_bcd;
          cnt_d   = DigitCntW'(NumDigits);
          state_d = neg_q ? StSign : StSkip;
        end
      end
      StSign: begin
        vld_d           = 1'b1;
        out_d.char_code = CharMinus;
        out_d.last_char = 1'b0;
        state_d         = StSkip;
      end
      StSkip: begin
        if ((top_nib == 4'd0) && (cnt_q > DigitCntW'(1))) begin
          dig_d = {dig_q[BcdWidth-5:0], 4'd0};
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        vld_d           = 1'b1;
        out_d.char_code = nib_ascii(top_nib);
        out_d.last_char = (cnt_q == DigitCntW'(1));
        dig_d           = {dig_q[BcdWidth-5:0], 4'd0};
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == DigitCntW'(1)) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      vld_q   <= vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dig_q <= dig_d;
    out_q <= out_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign res_valid_o = vld_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/itoa_dabble.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial binary to BCD converter (shift and add 3), one input bit per cycle.
module itoa_dabble
  import itoa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ValueWidth-1:0] bin_i,
  output      logic                  done_o,
  output      logic [BcdWidth-1:0]   bcd_o
);

  localparam logic [ShiftCntW-1:0] LastShift = ShiftCntW'(ValueWidth - 1);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [ShiftCntW-1:0]  cnt_q, cnt_d;
  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [BcdWidth-1:0]   bcd_adj;

  // Add 3 to every digit that is 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Shift sequencer
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      bin_d = bin_i;
      bcd_d = '0;
    end else if (run_q) begin
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
      bin_d = {bin_q[ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastShift) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data path, no reset
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/itoa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the formatter
module itoa_checker
  import itoa_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire itoa_in_t  in_i,
  input wire logic      busy_o,
  input wire logic      res_valid_o,
  input wire itoa_out_t res_o
);

  // A beat with a valid action keeps the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.action != ActNone)) |=> busy_o)
    else $error("busy_o not raised after start");

  // A dropped action produces no character
  a_none_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (in_i.action == ActNone)) |=> (!res_valid_o && !busy_o))
    else $error("output seen for unused action");

  // More characters follow, so the block is still working
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last_char) |-> busy_o)
    else $error("non-final character while idle");

  // The final character frees the block
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last_char) |-> !busy_o)
    else $error("still busy on final character");

endmodule

bind integer_to_ascii_formatter_top itoa_checker u_itoa_checker (.*);

`default_nettype wire

// ===== verif/itoa_char_checker.sv =====
`timescale 1ns / 1ps

// Watches the command and character channels of the formatter, predicts the
// character run of each accepted word and checks every strobed beat in order.
module itoa_char_checker
  import itoa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  itoa_in_t    in_i,
  input  logic        busy_o,
  input  logic        res_valid_o,
  input  itoa_out_t   res_o,
  output int unsigned mismatch_cnt,
  output int unsigned chars_pending
);

  // Characters still owed by the block, oldest first
  itoa_out_t pending_chars[$];

  initial begin
    mismatch_cnt  = 0;
    chars_pending = 0;
  end

  // Count a failure; only the first few get printed
  function automatic void flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // Expected character run for one word, most significant character first
  function automatic void predict_ascii(itoa_in_t item);
    logic [ValueWidth-1:0] mag;
    logic [3:0]            digit;
    logic [CharWidth-1:0]  run[$];
    logic                  minus;
    itoa_out_t             beat;
    if (item.action == ActNone) begin
      return;
    end
    minus = (item.action == ActSigned) && item.value[ValueWidth-1];
    // two's complement magnitude; the most negative value maps onto itself
    mag = minus ? (~item.value + 32'd1) : item.value;
    do begin
      if (item.action == ActHex) begin
        digit = mag[3:0];
        mag   = mag >> 4;
      end else begin
        digit = 4'(mag % 32'd10);
        mag   = mag / 32'd10;
      end
      run.push_front((digit >= 4'd10) ? CharLowA + 7'(digit - 4'd10) : CharZero + 7'(digit));
    end while (mag != 0 && run.size() < NumDigits);
    if (minus) begin
      run.push_front(CharMinus);
    end
    foreach (run[i]) begin
      beat.char_code = run[i];
      beat.last_char = (i == run.size() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  // Compare strobed beats, then queue the run of a word taken at this edge
  always @(posedge clk_i) begin
    itoa_out_t exp_beat;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (pending_chars.size() == 0) begin
          flag_error($sformatf("char %h last %0b strobed with nothing expected",
                               res_o.char_code, res_o.last_char));
        end else begin
          exp_beat = pending_chars.pop_front();
          if (res_o.char_code !== exp_beat.char_code ||
              res_o.last_char !== exp_beat.last_char) begin
            flag_error($sformatf("mismatch: expected char %h last %0b, got char %h last %0b",
                                 exp_beat.char_code, exp_beat.last_char,
                                 res_o.char_code, res_o.last_char));
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_ascii(in_i);
      end
    end
    chars_pending <= pending_chars.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import itoa_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned WordsPerPhase = 95;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  itoa_in_t    in_i;
  logic        busy_o;
  logic        res_valid_o;
  itoa_out_t   res_o;
  int unsigned mismatch_cnt;
  int unsigned chars_pending;
  int unsigned cycle_cnt = 0;
  int unsigned words_by_action[4] = '{0, 0, 0, 0};

  integer_to_ascii_formatter_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .in_i        (in_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  itoa_char_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .in_i          (in_i),
    .busy_o        (busy_o),
    .res_valid_o   (res_valid_o),
    .res_o         (res_o),
    .mismatch_cnt  (mismatch_cnt),
    .chars_pending (chars_pending)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[integer_to_ascii_formatter_top] ERROR");
      $finish;
    end
  end

  // Hold one word on the command port until the block takes it
  task automatic send_word(logic [ValueWidth-1:0] value, logic [ActWidth-1:0] action);
    start_i <= 1'b1;
    in_i    <= '{value: value, action: action};
    do @(posedge clk_i); while (busy_o);
    words_by_action[action]++;
  endtask

  // Random sender gap, pct percent chance per cycle
  task automatic idle_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every expected character has come out
  task automatic wait_for_drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (chars_pending != 0);
  endtask

  function automatic logic [ActWidth-1:0] pick_action();
    logic [ActWidth-1:0] act;
    if ($urandom_range(19) == 0) begin
      act = ActNone;
    end else begin
      case ($urandom_range(2))
        0:       act = ActSigned;
        1:       act = ActUnsigned;
        default: act = ActHex;
      endcase
    end
    return act;
  endfunction

  // Mix of full-range words, small numbers, single bits, decade edges,
  // small negatives and the signed boundary
  function automatic logic [ValueWidth-1:0] pick_value();
    logic [ValueWidth-1:0] val;
    logic [ValueWidth-1:0] decade;
    decade = 32'd1;
    case ($urandom_range(5))
      0: val = $urandom();
      1: val = $urandom_range(99);
      2: val = 32'd1 << $urandom_range(31);
      3: begin
        repeat ($urandom_range(9)) decade = decade * 32'd10;
        val = decade + $urandom_range(2) - 32'd1;
      end
      4: val = -32'($urandom_range(1000));
      default: val = ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFC) + $urandom_range(3);
    endcase
    return val;
  endfunction

  // Random words until the quota of converting items is reached
  task automatic run_phase(int unsigned pct, int unsigned quota);
    int unsigned         sent;
    logic [ActWidth-1:0] act;
    sent = 0;
    while (sent < quota) begin
      act = pick_action();
      idle_gap(pct);
      send_word(pick_value(), act);
      if (act != ActNone) begin
        sent++;
      end
    end
    wait_for_drain();
  endtask

  initial begin
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    in_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, extremes, digit and sign edges, dropped code
    send_word(32'd0,          ActSigned);
    send_word(32'd0,          ActUnsigned);
    send_word(32'd0,          ActHex);
    send_word(32'hFFFF_FFFF,  ActSigned);
    send_word(32'hFFFF_FFFF,  ActUnsigned);
    send_word(32'hFFFF_FFFF,  ActHex);
    send_word(32'h8000_0000,  ActSigned);
    send_word(32'h8000_0000,  ActUnsigned);
    send_word(32'h8000_0000,  ActHex);
    send_word(32'h7FFF_FFFF,  ActSigned);
    send_word(32'h8000_0001,  ActSigned);
    idle_gap(21);
    send_word(32'd9,          ActSigned);
    send_word(32'd10,         ActUnsigned);
    send_word(32'd1000000000, ActUnsigned);
    send_word(32'd999999999,  ActSigned);
    send_word(32'hF,          ActHex);
    send_word(32'h10,         ActHex);
    send_word(32'hABCD_EF01,  ActHex);
    send_word(32'hDEAD_BEEF,  ActNone);
    send_word(32'd5,          ActSigned);
    send_word(32'hFFFF_FFF6,  ActSigned);
    wait_for_drain();

    // Random: sender gaps at 21 %, then 58 %, then back to back
    run_phase(21, WordsPerPhase);
    run_phase(58, WordsPerPhase);
    run_phase(0,  WordsPerPhase);

    repeat (60) @(posedge clk_i);
    $display("covered %0d signed, %0d unsigned, %0d hex words and %0d dropped codes",
             words_by_action[ActSigned], words_by_action[ActUnsigned],
             words_by_action[ActHex], words_by_action[ActNone]);
    $display("%0d character mismatches over %0d cycles", mismatch_cnt, cycle_cnt);
    if (mismatch_cnt == 0) begin
      $display("[integer_to_ascii_formatter_top] OK");
    end else begin
      $display("[integer_to_ascii_formatter_top] ERROR");
    end
    $finish;
  end

endmodule
